@@ src/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg: shared types and codes of the c subset tokenizer
// token kinds, error codes and the front-to-back result record
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int KindW = 6;
  localparam int ErrW  = 3;

  localparam logic [KindW-1:0] K_STAR = 6'd0, K_SLASH = 6'd1, K_MOD = 6'd2, K_XOR = 6'd3,
    K_INVERT = 6'd4, K_SEMI = 6'd5, K_COMMA = 6'd6, K_LBRACE = 6'd7, K_RBRACE = 6'd8,
    K_LPAREN = 6'd9, K_RPAREN = 6'd10, K_LBRACKET = 6'd11, K_RBRACKET = 6'd12,
    K_PLUS = 6'd13, K_INC = 6'd14, K_MINUS = 6'd15, K_DEC = 6'd16, K_OR = 6'd17,
    K_LOR = 6'd18, K_AND = 6'd19, K_LAND = 6'd20, K_ASSIGN = 6'd21, K_EQ = 6'd22,
    K_NOT = 6'd23, K_NEQ = 6'd24, K_LT = 6'd25, K_LE = 6'd26, K_SHL = 6'd27,
    K_GT = 6'd28, K_GE = 6'd29, K_SHR = 6'd30, K_DOT = 6'd31, K_ELLIPSIS = 6'd32,
    K_INTLIT = 6'd33, K_CHARLIT = 6'd34, K_CHAR_OUT = 6'd35, K_IDENT_END = 6'd36,
    K_STRING_END = 6'd37, K_END = 6'd38, K_KW_FIRST = 6'd39;

  localparam logic [ErrW-1:0] E_NONE = 3'd0, E_BAD_CHAR = 3'd1, E_BAD_ESC = 3'd2,
    E_NO_CLOSE = 3'd3, E_EARLY_END = 3'd4;

  // one result as it travels from front to back
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [31:0]      value;
    logic [ErrW-1:0]  err;
    logic [31:0]      line;
    logic             last;
  } result_t;

endpackage

@@ src/cst_front.sv @@
// ----------------------------------------------------------------------------
// cst_front: scanner
// classifies each byte, runs the lexer state and emits up to two results
// ----------------------------------------------------------------------------
module cst_front #(
  parameter int VALUE_BITS      = 32,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       in_byte,
  input  logic             end_of_input,
  output logic [1:0]       res_count,
  output cst_pkg::result_t res0,
  output cst_pkg::result_t res1
);
  import cst_pkg::*;

  localparam int LenW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int IdxW = $clog2(KEYWORD_MAX_LEN);

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_DOT2, M_INT, M_IDENT, M_CHAR_OPEN, M_CHAR_ESC,
    M_CHAR_CLOSE, M_STR, M_STR_ESC
  } mode_t;

  mode_t                  mode, mode_next;
  logic [7:0]             pending_char, pending_char_next;
  logic [VALUE_BITS-1:0]  int_accum, int_accum_next;
  logic [7:0]             keyword_buffer [KEYWORD_MAX_LEN];
  logic [LenW-1:0]        ident_length, ident_length_next;
  logic [31:0]            line_count, line_count_next;
  logic                   halted, halted_next;
  logic                   kb_we;
  logic [IdxW-1:0]        kb_idx;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic logic [8:0] esc_val(input logic [7:0] b);
    case (b)
      "a": return 9'd7;
      "b": return 9'd8;
      "f": return 9'd12;
      "n": return 9'd10;
      "r": return 9'd13;
      "t": return 9'd9;
      "v": return 9'd11;
      8'h5c, 8'h22, 8'h27: return {1'b1, b};
      default: return 9'd0;
    endcase
  endfunction
  function automatic logic [KindW-1:0] op_single(input logic [7:0] c);
    case (c)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "|": return K_OR;
      "&": return K_AND;
      "=": return K_ASSIGN;
      "!": return K_NOT;
      "<": return K_LT;
      ">": return K_GT;
      default: return K_DOT;
    endcase
  endfunction
  function automatic logic [KindW:0] op_pair(input logic [7:0] c, input logic [7:0] b);
    if (c == "+" && b == "+") return {1'b1, K_INC};
    if (c == "-" && b == "-") return {1'b1, K_DEC};
    if (c == "|" && b == "|") return {1'b1, K_LOR};
    if (c == "&" && b == "&") return {1'b1, K_LAND};
    if (c == "=" && b == "=") return {1'b1, K_EQ};
    if (c == "!" && b == "=") return {1'b1, K_NEQ};
    if (c == "<" && b == "=") return {1'b1, K_LE};
    if (c == "<" && b == "<") return {1'b1, K_SHL};
    if (c == ">" && b == "=") return {1'b1, K_GE};
    if (c == ">" && b == ">") return {1'b1, K_SHR};
    return '0;
  endfunction

  function automatic logic kw_match(input logic [7:0] kb [KEYWORD_MAX_LEN],
                                    input logic [LenW-1:0] len,
                                    input logic [47:0] txt, input int n);
    logic ok;
    ok = (len == LenW'(n)) && (n <= KEYWORD_MAX_LEN);
    for (int i = 0; i < 6; i++)
      if (i < n && i < KEYWORD_MAX_LEN) ok = ok && (kb[i] == txt[47-8*i -: 8]);
    return ok;
  endfunction

  logic [KindW-1:0] close_kind;
  always_comb begin
    close_kind = K_IDENT_END;
    if      (kw_match(keyword_buffer, ident_length, {"void", 16'h0}, 4))
      close_kind = K_KW_FIRST;
    else if (kw_match(keyword_buffer, ident_length, {"int", 24'h0}, 3))
      close_kind = K_KW_FIRST + 6'd1;
    else if (kw_match(keyword_buffer, ident_length, {"char", 16'h0}, 4))
      close_kind = K_KW_FIRST + 6'd2;
    else if (kw_match(keyword_buffer, ident_length, {"long", 16'h0}, 4))
      close_kind = K_KW_FIRST + 6'd3;
    else if (kw_match(keyword_buffer, ident_length, {"if", 32'h0}, 2))
      close_kind = K_KW_FIRST + 6'd4;
    else if (kw_match(keyword_buffer, ident_length, {"else", 16'h0}, 4))
      close_kind = K_KW_FIRST + 6'd5;
    else if (kw_match(keyword_buffer, ident_length, {"while", 8'h0}, 5))
      close_kind = K_KW_FIRST + 6'd6;
    else if (kw_match(keyword_buffer, ident_length, {"for", 24'h0}, 3))
      close_kind = K_KW_FIRST + 6'd7;
    else if (kw_match(keyword_buffer, ident_length, "return", 6))
      close_kind = K_KW_FIRST + 6'd8;
  end

  // multiply by ten as two shifts and an add
  logic [VALUE_BITS-1:0] acc_times10;
  assign acc_times10 = (int_accum << 3) + (int_accum << 1);

  logic [1:0]       n;
  logic [KindW-1:0] k0, k1;
  logic [31:0]      v0, v1;
  logic [ErrW-1:0]  e0, e1;
  logic [8:0]       esc;
  logic [KindW:0]   pair;
  logic             tail_idle;

  always_comb begin
    mode_next = mode; pending_char_next = pending_char; int_accum_next = int_accum;
    ident_length_next = ident_length; line_count_next = line_count;
    halted_next = halted; kb_we = 1'b0; kb_idx = '0;
    n = 2'd0; k0 = K_END; k1 = K_END; v0 = '0; v1 = '0; e0 = E_NONE; e1 = E_NONE;
    esc = esc_val(in_byte);
    pair = op_pair(pending_char, in_byte);
    tail_idle = 1'b0;
    if (!halted) begin
      case (mode)
        M_IDLE: tail_idle = 1'b1;
        M_OP: begin
          if (!end_of_input && pending_char == "." && in_byte == ".") begin
            mode_next = M_DOT2;
          end else if (!end_of_input && pair[KindW]) begin
            n = 2'd1; k0 = pair[KindW-1:0]; mode_next = M_IDLE;
          end else begin
            n = 2'd1; k0 = op_single(pending_char); tail_idle = 1'b1;
          end
        end
        M_DOT2: begin
          n = 2'd1;
          if (!end_of_input && in_byte == ".") begin
            k0 = K_ELLIPSIS; mode_next = M_IDLE;
          end else begin
            e0 = E_BAD_CHAR; v0 = end_of_input ? 32'd0 : {24'd0, in_byte};
            halted_next = 1'b1; mode_next = M_IDLE;
          end
        end
        M_INT: begin
          if (!end_of_input && is_digit(in_byte)) begin
            int_accum_next = acc_times10 + VALUE_BITS'(in_byte - 8'd48);
          end else begin
            n = 2'd1; k0 = K_INTLIT; tail_idle = 1'b1;
            v0 = 32'(int_accum);
          end
        end
        M_IDENT: begin
          if (!end_of_input && (is_alpha(in_byte) || is_digit(in_byte) || in_byte == "_"))
          begin
            n = 2'd1; k0 = K_CHAR_OUT; v0 = {24'd0, in_byte};
            if (ident_length < LenW'(KEYWORD_MAX_LEN)) begin
              kb_we = 1'b1; kb_idx = IdxW'(ident_length);
            end
            if (ident_length <= LenW'(KEYWORD_MAX_LEN))
              ident_length_next = ident_length + 1'b1;
          end else begin
            n = 2'd1; k0 = close_kind; tail_idle = 1'b1;
          end
        end
        M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_STR, M_STR_ESC: begin
          if (end_of_input) begin
            n = 2'd1; e0 = E_EARLY_END; halted_next = 1'b1; mode_next = M_IDLE;
          end else begin
            case (mode)
              M_CHAR_OPEN: begin
                if (in_byte == 8'h5c) mode_next = M_CHAR_ESC;
                else begin
                  pending_char_next = in_byte; mode_next = M_CHAR_CLOSE;
                end
              end
              M_CHAR_ESC: begin
                if (!esc[8] && esc[7:0] == 8'd0) begin
                  n = 2'd1; e0 = E_BAD_ESC; v0 = {24'd0, in_byte};
                  halted_next = 1'b1; mode_next = M_IDLE;
                end else begin
                  pending_char_next = esc[7:0]; mode_next = M_CHAR_CLOSE;
                end
              end
              M_CHAR_CLOSE: begin
                n = 2'd1; mode_next = M_IDLE;
                if (in_byte == 8'h27) begin
                  k0 = K_CHARLIT; v0 = {24'd0, pending_char};
                end else begin
                  e0 = E_NO_CLOSE; v0 = {24'd0, in_byte}; halted_next = 1'b1;
                end
              end
              M_STR: begin
                if (in_byte == 8'h22) begin
                  n = 2'd1; k0 = K_STRING_END; mode_next = M_IDLE;
                end else if (in_byte == 8'h5c) begin
                  mode_next = M_STR_ESC;
                end else begin
                  n = 2'd1; k0 = K_CHAR_OUT; v0 = {24'd0, in_byte};
                end
              end
              default: begin
                n = 2'd1;
                if (!esc[8] && esc[7:0] == 8'd0) begin
                  e0 = E_BAD_ESC; v0 = {24'd0, in_byte};
                  halted_next = 1'b1; mode_next = M_IDLE;
                end else begin
                  k0 = K_CHAR_OUT; v0 = {24'd0, esc[7:0]}; mode_next = M_STR;
                end
              end
            endcase
          end
        end
        default: mode_next = M_IDLE;
      endcase

      // byte handled as at the start of a token, after any flushed result
      if (tail_idle) begin
        mode_next = M_IDLE;
        if (end_of_input) begin
          n = n + 2'd1; k1 = K_END;
        end else begin
          case (in_byte) inside
            8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: ;
            8'h0a: line_count_next = line_count + 32'd1;
            "*", "/", "%", "^", "~", ";", ",", "{", "}", "(", ")", "[", "]": begin
              n = n + 2'd1;
              case (in_byte)
                "*": k1 = K_STAR;
                "/": k1 = K_SLASH;
                "%": k1 = K_MOD;
                "^": k1 = K_XOR;
                "~": k1 = K_INVERT;
                ";": k1 = K_SEMI;
                ",": k1 = K_COMMA;
                "{": k1 = K_LBRACE;
                "}": k1 = K_RBRACE;
                "(": k1 = K_LPAREN;
                ")": k1 = K_RPAREN;
                "[": k1 = K_LBRACKET;
                default: k1 = K_RBRACKET;
              endcase
            end
            "+", "-", "|", "&", "=", "!", "<", ">", ".": begin
              pending_char_next = in_byte; mode_next = M_OP;
            end
            8'h27: mode_next = M_CHAR_OPEN;
            8'h22: mode_next = M_STR;
            ["0":"9"]: begin
              int_accum_next = VALUE_BITS'(in_byte - 8'd48); mode_next = M_INT;
            end
            ["a":"z"], ["A":"Z"], "_": begin
              n = n + 2'd1; k1 = K_CHAR_OUT; v1 = {24'd0, in_byte};
              kb_we = 1'b1; kb_idx = '0; ident_length_next = LenW'(1);
              mode_next = M_IDENT;
            end
            default: begin
              n = n + 2'd1; e1 = E_BAD_CHAR; v1 = {24'd0, in_byte};
              halted_next = 1'b1;
            end
          endcase
        end
        // single tail result goes into slot zero
        if (n == 2'd1 && !(mode == M_OP || mode == M_INT || mode == M_IDENT)) begin
          k0 = k1; v0 = v1; e0 = e1;
        end
      end
    end
  end

  always_comb begin
    res_count = n;
    res0 = '{kind: k0, value: v0, err: e0, line: line_count, last: n == 2'd1};
    res1 = '{kind: k1, value: v1, err: e1, line: line_count, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pending_char <= '0; int_accum <= '0; ident_length <= '0;
      line_count <= 32'd1; halted <= 1'b0;
    end else if (take) begin
      mode <= mode_next; pending_char <= pending_char_next;
      int_accum <= int_accum_next; ident_length <= ident_length_next;
      line_count <= line_count_next; halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && kb_we) keyword_buffer[kb_idx] <= in_byte;
  end

endmodule

@@ src/cst_queue.sv @@
// ----------------------------------------------------------------------------
// cst_queue: result queue
// four-entry fifo, takes up to two results per cycle, unless stalled gives one per cycle
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_count,
  input  cst_pkg::result_t wr0,
  input  cst_pkg::result_t wr1,
  output logic             room2,
  output logic             valid,
  input  logic             stall,
  output cst_pkg::result_t rd
);
  import cst_pkg::*;

  result_t    mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       pop;

  assign valid = cnt != 3'd0;
  assign pop   = valid && !stall;
  assign room2 = cnt <= 3'd2;
  assign rd    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp  <= wp + wr_count;
      rp  <= rp + 2'(pop);
      cnt <= cnt + 3'(wr_count) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) mem[wp] <= wr0;
    if (wr_count == 2'd2) mem[wp + 2'd1] <= wr1;
  end

endmodule

@@ src/c_subset_tokenizer.sv @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer: byte-serial lexer for a small c subset
// scanner front end feeding a small result queue toward the token port
// ----------------------------------------------------------------------------
// One source byte is taken per cycle whenever the result queue has room for
// two more results; a byte yields zero, one or two token beats, which leave
// one per cycle while out_stall is low. Sustained rate is one byte per clock;
// only bytes making two results, or downstream stall, can fill the four-entry
// queue and pause input. After an error beat (kind end, nonzero error_code) the
// block takes bytes but produces nothing until reset.
module c_subset_tokenizer #(
  parameter int VALUE_BITS      = 32,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [31:0] token_value,
  output logic [2:0]  error_code,
  output logic [31:0] line_number,
  output logic        last_result
);
  import cst_pkg::*;

  logic       take, room2;
  logic [1:0] cnt, wr_count;
  result_t    r0, r1, rd;

  // stall on queue space only, so acceptance never depends on the byte
  assign in_stall = !room2;
  assign take     = in_valid && room2;
  assign wr_count = take ? cnt : 2'd0;

  cst_front #(.VALUE_BITS(VALUE_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
    .clk, .rst, .take, .in_byte, .end_of_input,
    .res_count(cnt), .res0(r0), .res1(r1)
  );

  cst_queue u_queue (
    .clk, .rst, .wr_count, .wr0(r0), .wr1(r1), .room2,
    .valid(out_valid), .stall(out_stall), .rd
  );

  assign token_kind  = rd.kind;
  assign token_value = rd.value;
  assign error_code  = rd.err;
  assign line_number = rd.line;
  assign last_result = rd.last;

endmodule

@@ tb/tb_c_subset_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_c_subset_tokenizer: self-checking bench for the c subset tokenizer
// drives source bytes as beats, predicts every token beat with a behavioral
// lexer model and compares kind, value, error, line and last flag in order
// ----------------------------------------------------------------------------
module tb_c_subset_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int KwMax = 6;
  localparam int TailItems = 200;

  // scanner states of the predictor
  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_DOT2, S_INT, S_IDENT, S_CH_OPEN, S_CH_ESC, S_CH_CLOSE, S_STR, S_STR_ESC
  } scan_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } src_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [31:0] token_value;
  logic [2:0]  error_code;
  logic [31:0] line_number;
  logic        last_result;

  c_subset_tokenizer i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .end_of_input,
    .out_valid, .out_stall, .token_kind, .token_value, .error_code,
    .line_number, .last_result
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  src_beat_t pending_src[$];
  result_t   expected_tokens[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  // lexer model state
  scan_e       lx_mode = S_IDLE;
  logic [7:0]  lx_pend = 8'd0;
  logic [31:0] lx_accum = 32'd0;
  logic [7:0]  lx_kwbuf [KwMax];
  int          lx_len = 0;
  logic [31:0] lx_line = 32'd1;
  bit          lx_halted = 1'b0;
  result_t     step_out[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic emit(input logic [5:0] kind, input logic [31:0] value,
                      input logic [2:0] err);
    result_t r;
    if (step_out.size() < 2) begin
      r.kind = kind; r.value = value; r.err = err; r.line = lx_line; r.last = 1'b0;
      step_out.push_back(r);
    end
  endtask

  task automatic lex_fail(input logic [2:0] err, input logic [7:0] value);
    emit(K_END, {24'd0, value}, err);
    lx_halted = 1'b1;
    lx_mode = S_IDLE;
  endtask

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic int escape_code(input logic [7:0] b);
    case (b)
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      "\\", "\"", "'": return int'(b);
      default: return -1;
    endcase
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    case (c)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "|": return K_OR;
      "&": return K_AND;
      "=": return K_ASSIGN;
      "!": return K_NOT;
      "<": return K_LT;
      ">": return K_GT;
      default: return K_DOT;
    endcase
  endfunction

  function automatic int pair_op(input logic [7:0] c, input logic [7:0] b);
    string p;
    p = {string'(c), string'(b)};
    case (p)
      "++": return K_INC;
      "--": return K_DEC;
      "||": return K_LOR;
      "&&": return K_LAND;
      "==": return K_EQ;
      "!=": return K_NEQ;
      "<=": return K_LE;
      "<<": return K_SHL;
      ">=": return K_GE;
      ">>": return K_SHR;
      default: return -1;
    endcase
  endfunction

  // keyword kind for a closed identifier, identifier end otherwise
  function automatic logic [5:0] ident_kind();
    string words[9] = '{"void", "int", "char", "long", "if", "else", "while", "for", "return"};
    string seen;
    if (lx_len > KwMax) return K_IDENT_END;
    seen = "";
    for (int i = 0; i < lx_len; i++) seen = {seen, string'(lx_kwbuf[i])};
    for (int i = 0; i < 9; i++)
      if (seen == words[i]) return K_KW_FIRST + 6'(i);
    return K_IDENT_END;
  endfunction

  task automatic lex_idle(input logic [7:0] b);
    lx_mode = S_IDLE;
    case (b)
      " ", "\t", 8'h0b, 8'h0c, 8'h0d: ;
      "\n": lx_line++;
      "*": emit(K_STAR, 32'd0, E_NONE);
      "/": emit(K_SLASH, 32'd0, E_NONE);
      "%": emit(K_MOD, 32'd0, E_NONE);
      "^": emit(K_XOR, 32'd0, E_NONE);
      "~": emit(K_INVERT, 32'd0, E_NONE);
      ";": emit(K_SEMI, 32'd0, E_NONE);
      ",": emit(K_COMMA, 32'd0, E_NONE);
      "{": emit(K_LBRACE, 32'd0, E_NONE);
      "}": emit(K_RBRACE, 32'd0, E_NONE);
      "(": emit(K_LPAREN, 32'd0, E_NONE);
      ")": emit(K_RPAREN, 32'd0, E_NONE);
      "[": emit(K_LBRACKET, 32'd0, E_NONE);
      "]": emit(K_RBRACKET, 32'd0, E_NONE);
      "+", "-", "|", "&", "=", "!", "<", ">", ".": begin
        lx_pend = b;
        lx_mode = S_OP;
      end
      "'": lx_mode = S_CH_OPEN;
      "\"": lx_mode = S_STR;
      default: begin
        if (is_digit(b)) begin
          lx_accum = 32'(b - "0");
          lx_mode = S_INT;
        end else if (is_letter(b) || b == "_") begin
          emit(K_CHAR_OUT, {24'd0, b}, E_NONE);
          lx_kwbuf[0] = b;
          lx_len = 1;
          lx_mode = S_IDENT;
        end else begin
          lex_fail(E_BAD_CHAR, b);
        end
      end
    endcase
  endtask

  // one source beat through the lexer model; results land on expected_tokens
  task automatic predict_tokens(input src_beat_t s);
    logic [7:0] b;
    int k;
    b = s.data;
    step_out.delete();
    if (!lx_halted) begin
      case (lx_mode)
        S_IDLE:
          if (s.eoi) emit(K_END, 32'd0, E_NONE);
          else lex_idle(b);
        S_OP: begin
          k = pair_op(lx_pend, b);
          if (s.eoi) begin
            emit(single_op(lx_pend), 32'd0, E_NONE);
            emit(K_END, 32'd0, E_NONE);
            lx_mode = S_IDLE;
          end else if (lx_pend == "." && b == ".") begin
            lx_mode = S_DOT2;
          end else if (k >= 0) begin
            emit(6'(k), 32'd0, E_NONE);
            lx_mode = S_IDLE;
          end else begin
            emit(single_op(lx_pend), 32'd0, E_NONE);
            lex_idle(b);
          end
        end
        S_DOT2:
          if (!s.eoi && b == ".") begin
            emit(K_ELLIPSIS, 32'd0, E_NONE);
            lx_mode = S_IDLE;
          end else begin
            lex_fail(E_BAD_CHAR, s.eoi ? 8'd0 : b);
          end
        S_INT:
          if (!s.eoi && is_digit(b)) begin
            lx_accum = lx_accum * 32'd10 + 32'(b - "0");
          end else begin
            emit(K_INTLIT, lx_accum, E_NONE);
            lx_mode = S_IDLE;
            if (s.eoi) emit(K_END, 32'd0, E_NONE);
            else lex_idle(b);
          end
        S_IDENT:
          if (!s.eoi && (is_letter(b) || is_digit(b) || b == "_")) begin
            emit(K_CHAR_OUT, {24'd0, b}, E_NONE);
            if (lx_len < KwMax) lx_kwbuf[lx_len] = b;
            if (lx_len <= KwMax) lx_len++;
          end else begin
            emit(ident_kind(), 32'd0, E_NONE);
            lx_mode = S_IDLE;
            if (s.eoi) emit(K_END, 32'd0, E_NONE);
            else lex_idle(b);
          end
        S_CH_OPEN:
          if (s.eoi) lex_fail(E_EARLY_END, 8'd0);
          else if (b == "\\") lx_mode = S_CH_ESC;
          else begin
            lx_pend = b;
            lx_mode = S_CH_CLOSE;
          end
        S_CH_ESC: begin
          k = escape_code(b);
          if (s.eoi) lex_fail(E_EARLY_END, 8'd0);
          else if (k < 0) lex_fail(E_BAD_ESC, b);
          else begin
            lx_pend = 8'(k);
            lx_mode = S_CH_CLOSE;
          end
        end
        S_CH_CLOSE:
          if (s.eoi) lex_fail(E_EARLY_END, 8'd0);
          else if (b == "'") begin
            emit(K_CHARLIT, {24'd0, lx_pend}, E_NONE);
            lx_mode = S_IDLE;
          end else lex_fail(E_NO_CLOSE, b);
        S_STR:
          if (s.eoi) lex_fail(E_EARLY_END, 8'd0);
          else if (b == "\"") begin
            emit(K_STRING_END, 32'd0, E_NONE);
            lx_mode = S_IDLE;
          end else if (b == "\\") lx_mode = S_STR_ESC;
          else emit(K_CHAR_OUT, {24'd0, b}, E_NONE);
        S_STR_ESC: begin
          k = escape_code(b);
          if (s.eoi) lex_fail(E_EARLY_END, 8'd0);
          else if (k < 0) lex_fail(E_BAD_ESC, b);
          else begin
            emit(K_CHAR_OUT, 32'(k), E_NONE);
            lx_mode = S_STR;
          end
        end
        default: lx_mode = S_IDLE;
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
  endtask

  // stall as seen at the last rising edge, so the driver holds a refused beat
  logic in_stall_q = 1'b0;
  int   src_gap = 0;
  int   sink_gap = 0;

  // driver: valid held with a steady payload until the beat is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall_q)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_src.size() > 0) begin
          in_byte <= pending_src[0].data;
          end_of_input <= pending_src[0].eoi;
          in_valid <= 1'b1;
          void'(pending_src.pop_front());
          if (pending_src.size() > TailItems && $urandom_range(0, 9) == 0)
            src_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sink: random stall bursts, none near the end of the run
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (pending_src.size() > TailItems && $urandom_range(0, 11) == 0)
          sink_gap = $urandom_range(1, 15);
      end
    end
  end

  // monitor: beats on both sides sampled at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      in_stall_q <= in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        predict_tokens('{data: in_byte, eoi: end_of_input});
      end
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected beat kind", 32'(token_kind), 32'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind) report_mismatch("kind", 32'(token_kind), 32'(want.kind));
          if (token_value !== want.value) report_mismatch("value", token_value, want.value);
          if (error_code !== want.err) report_mismatch("error", 32'(error_code), 32'(want.err));
          if (line_number !== want.line) report_mismatch("line", line_number, want.line);
          if (last_result !== want.last)
            report_mismatch("last", 32'(last_result), 32'(want.last));
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++) pending_src.push_back('{data: text[i], eoi: 1'b0});
  endtask

  task automatic push_end();
    pending_src.push_back('{data: 8'($urandom_range(0, 255)), eoi: 1'b1});
  endtask

  // one random well-formed lexeme with random content
  function automatic string random_lexeme();
    string ops[] = '{"*", "/", "%", "^", "~", ";", ",", "{", "}", "(", ")", "[", "]",
      "+", "++", "-", "--", "|", "||", "&", "&&", "=", "==", "!", "!=", "<", "<=",
      "<<", ">", ">=", ">>", ".", "..."};
    string kws[] = '{"void", "int", "char", "long", "if", "else", "while", "for", "return"};
    string esc = "abfnrtv\\\"'";
    string s;
    int n;
    s = "";
    case ($urandom_range(0, 7))
      0, 1: s = ops[$urandom_range(0, ops.size() - 1)];
      2: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      end
      3: s = kws[$urandom_range(0, 8)];
      4: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 3))
            0: s = {s, "_"};
            1: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            2: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
            default: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
          endcase
        if (is_digit(s[0])) s[0] = "x";
      end
      5: begin
        if ($urandom_range(0, 1)) s = {"'\\", string'(esc[$urandom_range(0, 9)]), "'"};
        else s = {"'", string'(8'($urandom_range(1, 255))), "'"};
        if (s.len() == 3 && s[1] == "\\") s[1] = "x";
      end
      default: begin
        s = "\"";
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
          if ($urandom_range(0, 4) == 0) s = {s, "\\", string'(esc[$urandom_range(0, 9)])};
          else begin
            s = {s, string'(8'($urandom_range(1, 255)))};
            if (s[s.len() - 1] == "\"" || s[s.len() - 1] == "\\") s[s.len() - 1] = "q";
          end
        s = {s, "\""};
      end
    endcase
    return s;
  endfunction

  // reset, directed texts, random texts, error texts last, then drain
  initial begin
    int sent;
    string sep[] = '{" ", "\n", "\t", "", " \n "};
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: operators, escapes, quote char literal, keyword edge, numeric wrap
    push_text("a<<=...!=>>");
    push_end();
    push_text("'\\n' ''' \"x\\\"y\"\n4294967296 returns");
    push_end();

    // random: well-formed texts, every text closed by an end mark
    sent = 0;
    while (sent < 1550) begin
      int lexemes;
      lexemes = $urandom_range(1, 20);
      for (int i = 0; i < lexemes; i++) begin
        string t;
        t = random_lexeme();
        // a lone dot glued to another dot would read as a broken ellipsis
        if (t == ".") t = {t, " "};
        else t = {t, sep[$urandom_range(0, 4)]};
        push_text(t);
        sent += t.len();
      end
      push_end();
      sent++;
    end

    // errors: the first one halts the block, the rest must stay silent
    push_text("..;");  // two dots then something else
    push_end();
    push_text("\"abc");  // early end in a string
    push_end();
    push_text("'ab'");  // no closing quote
    push_end();
    push_text("\"\\q\"");  // bad escape
    push_end();
    push_text("@");
    push_end();
    pending_src.push_back('{data: 8'hff, eoi: 1'b0});
    push_end();

    wait (pending_src.size() == 0 && !in_valid && expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cst_pkg.sv
src/cst_front.sv
src/cst_queue.sv
src/c_subset_tokenizer.sv
tb/tb_c_subset_tokenizer.sv
